// ----- sv/csvfs_pkg.sv -----
// Shared types and constants of the CSV field splitter.
package csvfs_pkg;

  localparam int MAX_FIELDS = 256;
  localparam int FIELD_CAP = ((MAX_FIELDS - 1) < 255) ? (MAX_FIELDS - 1) : 255;
  localparam logic [7:0] FIELD_CAP_B = FIELD_CAP[7:0];

  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_NUL = 8'd0;

  localparam logic [7:0] SEP_RESET = 8'd44;
  localparam logic [7:0] QUOTE_RESET = 8'd34;

  localparam logic CFG_SEP = 1'b0;
  localparam logic CFG_QUOTE = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_LINE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    MODE_START  = 5'b00001,
    MODE_PLAIN  = 5'b00010,
    MODE_QUOTED = 5'b00100,
    MODE_QPEND  = 5'b01000,
    MODE_SKIP   = 5'b10000
  } mode_t;

  typedef enum logic [2:0] {
    SWALLOW_NONE = 3'b001,
    SWALLOW_LF   = 3'b010,
    SWALLOW_CR   = 3'b100
  } swallow_t;

  // One queued entry: an optional quote error ahead of the main result.
  typedef struct packed {
    logic       pre_err;
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] index;
  } entry_t;

endpackage

// ----- sv/csvfs_front.sv -----
// Front end: configuration registers, byte classification and parse state.
module csvfs_front import csvfs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_addr,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_eod,
  input  logic       q_full,
  output logic       push,
  output entry_t     push_entry
);

  logic [7:0] separator;
  logic [7:0] quote;
  mode_t      mode, mode_next;
  swallow_t   swallow, swallow_next;
  logic       line_open, line_open_next;
  logic [7:0] field_counter, field_counter_next;
  logic       accept;
  logic       is_quote, is_sep;
  logic       emit;

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;
  assign is_quote = (quote != CH_NUL) && (in_byte == quote);
  assign is_sep = (in_byte == separator);
  assign push = accept && emit;

  always_comb begin
    mode_next = mode;
    swallow_next = swallow;
    line_open_next = line_open;
    field_counter_next = field_counter;
    emit = 1'b0;
    push_entry.pre_err = 1'b0;
    push_entry.kind = KIND_BYTE;
    push_entry.data = 8'd0;
    push_entry.index = field_counter;
    if (in_eod || in_byte == CH_NUL) begin
      emit = line_open;
      push_entry.pre_err = (mode == MODE_QUOTED);
      push_entry.kind = KIND_LINE;
      mode_next = MODE_START;
      swallow_next = SWALLOW_NONE;
      line_open_next = 1'b0;
      field_counter_next = 8'd0;
    end else if ((swallow == SWALLOW_LF && in_byte == CH_LF) ||
                 (swallow == SWALLOW_CR && in_byte == CH_CR)) begin
      swallow_next = SWALLOW_NONE;
    end else if (in_byte == CH_CR || in_byte == CH_LF) begin
      emit = 1'b1;
      push_entry.pre_err = (mode == MODE_QUOTED);
      push_entry.kind = KIND_LINE;
      mode_next = MODE_START;
      line_open_next = 1'b0;
      field_counter_next = 8'd0;
      swallow_next = (in_byte == CH_CR) ? SWALLOW_LF : SWALLOW_CR;
    end else begin
      swallow_next = SWALLOW_NONE;
      line_open_next = 1'b1;
      case (mode)
        MODE_START, MODE_PLAIN, MODE_QPEND: begin
          if (mode == MODE_START && is_quote) begin
            mode_next = MODE_QUOTED;
          end else if (mode == MODE_QPEND && is_quote) begin
            emit = 1'b1;
            push_entry.data = in_byte;
            mode_next = MODE_QUOTED;
          end else if (is_sep) begin
            emit = 1'b1;
            push_entry.kind = KIND_FIELD;
            mode_next = MODE_START;
            if (field_counter < FIELD_CAP_B) begin
              field_counter_next = field_counter + 8'd1;
            end
          end else if (mode == MODE_QPEND) begin
            emit = 1'b1;
            push_entry.kind = KIND_ERROR;
            mode_next = MODE_SKIP;
          end else begin
            emit = 1'b1;
            push_entry.data = in_byte;
            mode_next = MODE_PLAIN;
          end
        end
        MODE_QUOTED: begin
          if (is_quote) begin
            mode_next = MODE_QPEND;
          end else begin
            emit = 1'b1;
            push_entry.data = in_byte;
          end
        end
        default: begin
          mode_next = MODE_SKIP;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      separator <= SEP_RESET;
      quote <= QUOTE_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SEP:   separator <= cfg_wdata;
        CFG_QUOTE: quote <= cfg_wdata;
        default:   separator <= separator;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_START;
      swallow <= SWALLOW_NONE;
      line_open <= 1'b0;
      field_counter <= 8'd0;
    end else if (accept) begin
      mode <= mode_next;
      swallow <= swallow_next;
      line_open <= line_open_next;
      field_counter <= field_counter_next;
    end
  end

endmodule

// ----- sv/csvfs_queue.sv -----
// Short queue of result entries between the front and back ends.
module csvfs_queue import csvfs_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output entry_t head
);

  entry_t              slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_pop;

  assign full = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head = slots[rd_ptr];
  assign do_pop = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      case ({push, do_pop})
        2'b10:   count <= count + (QUEUE_AW + 1)'(1);
        2'b01:   count <= count - (QUEUE_AW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/csvfs_back.sv -----
// Back end: expands queue entries into results and holds the output register.
module csvfs_back import csvfs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_not_empty,
  input  entry_t     q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic [7:0] out_index,
  output logic       out_last
);

  logic err_sent;
  logic load;
  logic first_err;

  assign load = q_not_empty && (!out_valid || out_ready);
  assign first_err = q_head.pre_err && !err_sent;
  assign q_pop = load && !first_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      err_sent <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        err_sent <= first_err;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_index <= q_head.index;
      if (first_err) begin
        out_kind <= KIND_ERROR;
        out_byte <= 8'd0;
        out_last <= 1'b0;
      end else begin
        out_kind <= q_head.kind;
        out_byte <= q_head.data;
        out_last <= 1'b1;
      end
    end
  end

endmodule

// ----- sv/csv_field_splitter_top.sv -----
// Top level of the CSV field splitter: front end, entry queue and back end.
// Accepts one byte per cycle; each result is held in the queue and then in the output register.
// A byte can give two results, a quote error and then its line result, each its own output transfer.
// The front end stalls only when the four-entry queue is full.
// Synchronous active-high reset restores separator 44, quote 34, empty state.
module csv_field_splitter_top import csvfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_data
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] field_byte, [15:8] field_index
  output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
  output logic        m_axis_tlast    // is_last
);

  logic   push;
  entry_t push_entry;
  logic   q_full;
  logic   q_pop;
  logic   q_not_empty;
  entry_t q_head;

  csvfs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .in_eod     (s_axis_tlast),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  csvfs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  csvfs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_kind    (m_axis_tuser),
    .out_byte    (m_axis_tdata[7:0]),
    .out_index   (m_axis_tdata[15:8]),
    .out_last    (m_axis_tlast)
  );

endmodule
